// ===== design/mcgp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mcgp_pkg;

    // Field widths fixed by the result word
    localparam int SUM_W = 32;
    localparam int IDX_W = 6;

    // Configuration register layout
    localparam int CFG_W   = 7;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic [CFG_W-1:0] GRID_ROWS_RST = 7'd64;
    localparam logic [CFG_W-1:0] GRID_COLS_RST = 7'd64;

    // Register index codes (byte address bit 2)
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    // Saturation limits
    localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

    // Position class of one cell, set by the front end
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_cell;
    } mcgp_cls_t;

    localparam int CLS_W = $bits(mcgp_cls_t);

endpackage

`default_nettype wire

// ===== design/mcgp_cost_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mcgp_cost_if #(
    parameter int COST_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [COST_BITS-1:0] cell_cost;

    modport source (output valid, output cell_cost, input ready);
    modport sink   (input valid, input cell_cost, output ready);
endinterface

`default_nettype wire

// ===== design/mcgp_sum_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mcgp_sum_if
    import mcgp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] path_sum;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic                    grid_done;

    modport source (output valid, output path_sum, output row_index, output col_index,
                    output grid_done, input ready);
    modport sink   (input valid, input path_sum, input row_index, input col_index,
                    input grid_done, output ready);
endinterface

`default_nettype wire

// ===== design/mcgp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcgp_front
    import mcgp_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int COST_BITS = 16,
    parameter int RW        = 6,
    parameter int CW        = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [PADDR_W-1:0]          paddr,
    input  wire logic [DATA_W-1:0]           pwdata,
    output logic      [DATA_W-1:0]           prdata,
    output logic                             pready,
    // incoming cost words
    mcgp_cost_if.sink                        cost_in,
    // push side of the queue
    output logic                             q_valid,
    input  wire logic                        q_ready,
    output logic signed [COST_BITS-1:0]      q_cost,
    output logic      [RW-1:0]               q_row,
    output logic      [CW-1:0]               q_col,
    output mcgp_cls_t                        q_cls
);

    localparam int RSW = $clog2(MAX_ROWS + 1);
    localparam int CSW = $clog2(MAX_COLS + 1);

    logic [CFG_W-1:0] grid_rows_reg;
    logic [CFG_W-1:0] grid_cols_reg;
    logic [RW-1:0]    r_reg, r_next;
    logic [CW-1:0]    c_reg, c_next;
    logic [RSW-1:0]   rows_eff;
    logic [CSW-1:0]   cols_eff;
    logic             cfg_wr;
    logic             push;
    logic             r_last;
    logic             c_last;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Hold the size registers; any write restarts the grid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_ROWS_RST;
            grid_cols_reg <= GRID_COLS_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_GRID_ROWS: grid_rows_reg <= pwdata[CFG_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= pwdata[CFG_W-1:0];
                default:       grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (paddr[2])
            REG_GRID_ROWS: prdata = DATA_W'(grid_rows_reg);
            REG_GRID_COLS: prdata = DATA_W'(grid_cols_reg);
            default:       prdata = '0;
        endcase
    end

    // Clamp sizes: zero acts as one, oversize acts as the maximum
    assign rows_eff = (grid_rows_reg == '0) ? RSW'(1) :
                      ((32'(grid_rows_reg) > MAX_ROWS) ? RSW'(MAX_ROWS) : RSW'(grid_rows_reg));
    assign cols_eff = (grid_cols_reg == '0) ? CSW'(1) :
                      ((32'(grid_cols_reg) > MAX_COLS) ? CSW'(MAX_COLS) : CSW'(grid_cols_reg));

    assign r_last = (RSW'(r_reg) == RSW'(rows_eff - RSW'(1)));
    assign c_last = (CSW'(c_reg) == CSW'(cols_eff - CSW'(1)));

    // Classify the word and push it
    assign cost_in.ready   = q_ready;
    assign q_valid         = cost_in.valid;
    assign push            = cost_in.valid && q_ready;
    assign q_cost          = cost_in.cell_cost;
    assign q_row           = r_reg;
    assign q_col           = c_reg;
    assign q_cls.first_row = (r_reg == '0);
    assign q_cls.first_col = (c_reg == '0);
    assign q_cls.last_cell = r_last && c_last;

    // Advance the position, wrapping at the grid end
    always_comb
    begin
        r_next = r_reg;
        c_next = c_reg;
        if (cfg_wr)
        begin
            r_next = '0;
            c_next = '0;
        end
        else if (push)
        begin
            if (c_last)
            begin
                c_next = '0;
                r_next = r_last ? '0 : RW'(r_reg + RW'(1));
            end
            else
            begin
                c_next = CW'(c_reg + CW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            r_reg <= r_next;
            c_reg <= c_next;
        end
    end

`ifndef SYNTH
    a_cfg_restart : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (r_reg == '0 && c_reg == '0))
        else $error("position not restarted after a register write");

    a_grid_wrap : assert property (@(posedge clk) disable iff (!rst_n)
        (push && q_cls.last_cell && !cfg_wr) |=> (r_reg == '0 && c_reg == '0))
        else $error("position did not wrap after the last cell");
`endif

endmodule

`default_nettype wire

// ===== design/mcgp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcgp_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : PW'(wr_ptr_reg + PW'(1));
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : PW'(rd_ptr_reg + PW'(1));
            end
            if (push && !pop)
            begin
                count_reg <= NW'(count_reg + NW'(1));
            end
            else if (pop && !push)
            begin
                count_reg <= NW'(count_reg - NW'(1));
            end
        end
    end

`ifndef SYNTH
    a_no_overfill : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == NW'(DEPTH) && !pop_ready) |=> (count_reg == NW'(DEPTH)))
        else $error("queue occupancy changed while full and stalled");
`endif

endmodule

`default_nettype wire

// ===== design/mcgp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcgp_back
    import mcgp_pkg::*;
#(
    parameter int MAX_COLS  = 64,
    parameter int COST_BITS = 16,
    parameter int RW        = 6,
    parameter int CW        = 6
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // pop side of the queue
    input  wire logic                   q_valid,
    output logic                        q_ready,
    input  wire logic signed [COST_BITS-1:0] q_cost,
    input  wire logic [RW-1:0]          q_row,
    input  wire logic [CW-1:0]          q_col,
    input  wire mcgp_cls_t              q_cls,
    // result words
    mcgp_sum_if.source                  sum_out
);

    // Row buffer: previous row's sums, one read and one write per cycle
    logic signed [SUM_W-1:0] row_mem [MAX_COLS];

    logic                        b1_valid_reg;
    logic signed [COST_BITS-1:0] b1_cost_reg;
    logic [RW-1:0]               b1_row_reg;
    logic [CW-1:0]               b1_col_reg;
    mcgp_cls_t                   b1_cls_reg;
    logic signed [SUM_W-1:0]     up_rd_reg;
    logic                        byp_reg;
    logic signed [SUM_W-1:0]     byp_val_reg;
    logic signed [SUM_W-1:0]     left_reg;
    logic signed [SUM_W-1:0]     diag_reg;

    logic                        out_valid_reg;
    logic signed [SUM_W-1:0]     out_sum_reg;
    logic [IDX_W-1:0]            out_row_reg;
    logic [IDX_W-1:0]            out_col_reg;
    logic                        out_done_reg;

    logic                        b1_fire;
    logic                        q_pop;
    logic signed [SUM_W-1:0]     up;
    logic signed [SUM_W-1:0]     min_ul;
    logic signed [SUM_W-1:0]     base;
    logic signed [SUM_W:0]       wide_sum;
    logic signed [SUM_W-1:0]     sum_next;

    assign b1_fire = b1_valid_reg && (!out_valid_reg || sum_out.ready);
    assign q_ready = !b1_valid_reg || b1_fire;
    assign q_pop   = q_valid && q_ready;

    // Up value: zero on the first row, forwarded when the same column was just written
    assign up = b1_cls_reg.first_row ? '0 : (byp_reg ? byp_val_reg : up_rd_reg);

    // Pick the predecessor sum, then add the cost with saturation
    always_comb
    begin
        min_ul = (left_reg < up) ? left_reg : up;
        if (b1_cls_reg.first_row && b1_cls_reg.first_col)
        begin
            base = '0;
        end
        else if (b1_cls_reg.first_row)
        begin
            base = left_reg;
        end
        else if (b1_cls_reg.first_col)
        begin
            base = up;
        end
        else
        begin
            base = (diag_reg < min_ul) ? diag_reg : min_ul;
        end
        wide_sum = (SUM_W+1)'(base) + (SUM_W+1)'(b1_cost_reg);
        if (wide_sum[SUM_W] != wide_sum[SUM_W-1])
        begin
            sum_next = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_next = wide_sum[SUM_W-1:0];
        end
    end

    // Row buffer write on compute, registered read on pop
    always_ff @(posedge clk)
    begin
        if (b1_fire)
        begin
            row_mem[b1_col_reg] <= sum_next;
        end
        if (q_pop)
        begin
            up_rd_reg <= row_mem[q_col];
        end
    end

    // Load the compute stage payload; on compute, load the output register and the left and diagonal sums
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_cost_reg <= q_cost;
            b1_row_reg  <= q_row;
            b1_col_reg  <= q_col;
            b1_cls_reg  <= q_cls;
            byp_val_reg <= sum_next;
        end
        if (b1_fire)
        begin
            left_reg    <= sum_next;
            diag_reg    <= up;
            out_sum_reg <= sum_next;
            out_row_reg <= IDX_W'(b1_row_reg);
            out_col_reg <= IDX_W'(b1_col_reg);
            out_done_reg <= b1_cls_reg.last_cell;
        end
    end

    // Control: stage valids and the forward flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_ready)
            begin
                b1_valid_reg <= q_valid;
            end
            if (q_pop)
            begin
                byp_reg <= b1_fire && (b1_col_reg == q_col);
            end
            if (b1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (sum_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sum_out.valid     = out_valid_reg;
    assign sum_out.path_sum  = out_sum_reg;
    assign sum_out.row_index = out_row_reg;
    assign sum_out.col_index = out_col_reg;
    assign sum_out.grid_done = out_done_reg;

`ifndef SYNTH
    a_fire_loads_out : assert property (@(posedge clk) disable iff (!rst_n)
        b1_fire |=> out_valid_reg)
        else $error("computed sum not held in the output register");

    a_forward_same_col : assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && b1_fire && b1_col_reg == q_col) |=> byp_reg)
        else $error("row buffer hazard not forwarded");
`endif

endmodule

`default_nettype wire

// ===== design/min_cost_grid_path_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Minimum-cost grid path engine. Cell costs stream in row-major order on cost_in, one
// word per cell, and each cell yields one word on sum_out: the least accumulated cost
// from the top-left cell by steps right, down or diagonally down-right, saturated to
// 32-bit signed, with its row and column and a grid_done flag on the bottom-right cell.
// The block sustains one word per clock while sum_out is ready; the limit is the row
// buffer, which takes one read and one write each cycle. Each accepted cost word passes
// through the queue, the compute stage and the output register. grid_rows and grid_cols
// live at byte addresses 0 and 4; writing either restarts the grid at row 0, column 0
// and must only happen while the block is idle. A size of 0 acts as 1, and a size above
// MAX_ROWS or MAX_COLS acts as that maximum. No clearing pass is needed after reset:
// row 0 fills the row buffer before any later row reads it.

module min_cost_grid_path_dp
    import mcgp_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int COST_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    mcgp_cost_if.sink               cost_in,
    mcgp_sum_if.source              sum_out
);

    localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ENT_W   = COST_BITS + RW + CW + CLS_W;
    localparam int Q_DEPTH = 2;

    logic                        f_valid;
    logic                        f_ready;
    logic signed [COST_BITS-1:0] f_cost;
    logic [RW-1:0]               f_row;
    logic [CW-1:0]               f_col;
    mcgp_cls_t                   f_cls;

    logic                        b_valid;
    logic                        b_ready;
    logic [ENT_W-1:0]            push_word;
    logic [ENT_W-1:0]            pop_word;
    logic signed [COST_BITS-1:0] b_cost;
    logic [RW-1:0]               b_row;
    logic [CW-1:0]               b_col;
    mcgp_cls_t                   b_cls;

    // Front end: registers, position tracking, classification
    mcgp_front #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .COST_BITS (COST_BITS),
        .RW        (RW),
        .CW        (CW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cost_in (cost_in),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_cost  (f_cost),
        .q_row   (f_row),
        .q_col   (f_col),
        .q_cls   (f_cls)
    );

    // Pack and unpack the queued word
    assign push_word = {f_cost, f_row, f_col, f_cls};
    assign b_cls     = pop_word[CLS_W-1:0];
    assign b_col     = pop_word[CLS_W +: CW];
    assign b_row     = pop_word[CLS_W+CW +: RW];
    assign b_cost    = pop_word[CLS_W+CW+RW +: COST_BITS];

    mcgp_queue #(
        .WIDTH (ENT_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (push_word),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (pop_word)
    );

    // Back end: row buffer, sum compute, output register
    mcgp_back #(
        .MAX_COLS  (MAX_COLS),
        .COST_BITS (COST_BITS),
        .RW        (RW),
        .CW        (CW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .q_cost  (b_cost),
        .q_row   (b_row),
        .q_col   (b_col),
        .q_cls   (b_cls),
        .sum_out (sum_out)
    );

endmodule

`default_nettype wire
